### src/sfp_pkg.sv
// Shared types and constants for the serial frame parser with sum check.
// Used by the channel interfaces, the parser, the result buffer and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sfp_pkg;

    localparam int unsigned ByteW       = 8;
    localparam int unsigned CfgIndexW   = 2;
    localparam int unsigned CfgDataW    = 8;
    localparam int unsigned BufDepth    = 3;
    localparam int unsigned BufPtrW     = $clog2(BufDepth);
    localparam int unsigned BufCntW     = $clog2(BufDepth + 1);

    localparam logic [ByteW-1:0] HeadByteReset  = 8'd170;
    localparam logic [ByteW-1:0] MaxLengthReset = 8'd100;

    // Configuration register indexes.
    localparam logic [CfgIndexW-1:0] CFG_HEAD_BYTE  = 2'd0;
    localparam logic [CfgIndexW-1:0] CFG_MAX_LENGTH = 2'd1;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    typedef enum logic [2:0] {
        PH_HEAD = 3'd0,
        PH_ADDR = 3'd1,
        PH_ID   = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4,
        PH_SUM  = 3'd5,
        PH_ADD  = 3'd6
    } phase_t;

    typedef struct packed {
        logic             kind;
        logic [ByteW-1:0] frame_id;
        logic [ByteW-1:0] payload_byte;
        logic [ByteW-1:0] byte_index;
        logic [ByteW-1:0] frame_length;
        logic             frame_good;
    } result_t;

endpackage

`default_nettype wire

### src/sfp_rx_if.sv
// Input channel of the frame parser: one received byte per beat.
// Depends on sfp_pkg for the byte width.
`timescale 1ns / 1ps
`default_nettype none

interface sfp_rx_if
    import sfp_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### src/sfp_tx_if.sv
// Result channel of the frame parser: one payload or end-of-frame beat.
// Depends on sfp_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sfp_tx_if
    import sfp_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             kind;
    logic [ByteW-1:0] frame_id;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] byte_index;
    logic [ByteW-1:0] frame_length;
    logic             frame_good;

    modport source (output valid, output kind, output frame_id, output payload_byte,
                    output byte_index, output frame_length, output frame_good,
                    input ready);
    modport sink   (input valid, input kind, input frame_id, input payload_byte,
                    input byte_index, input frame_length, input frame_good,
                    output ready);
endinterface

`default_nettype wire

### src/serial_frame_parser_sum_check_top.sv
// Top level of the serial frame parser with sum check.
// Depends on sfp_pkg, sfp_rx_if, sfp_tx_if, sfp_parser and sfp_result_buf.
`timescale 1ns / 1ps
`default_nettype none

// Takes one received byte per beat and deframes head, address, id, length,
// payload, sum, add frames. Every payload byte leaves as a beat of its own, and the
// add byte produces an end-of-frame beat whose frame_good flag reports whether the
// 8-bit sum of head through payload matched the sum byte. One byte is accepted per
// clock cycle while rx.ready is high; the byte is held in the input register and its
// result in the result buffer before it shows on the result channel. Parser logic
// between the input register and a three-entry result buffer forms the path; rx.ready
// drops only when the beats in the buffer plus the byte in the parser stage reach
// three, which happens only while the result side is holding off.
// Configuration writes are meant to happen while no frame is in progress.
module serial_frame_parser_sum_check_top
    import sfp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CfgIndexW-1:0] cfg_index,
    input  wire logic [CfgDataW-1:0]  cfg_data,
    sfp_rx_if.sink                    rx,
    sfp_tx_if.source                  tx
);

    logic               res_valid;
    result_t            res;
    result_t            out_data;
    logic [BufCntW-1:0] buf_count;

    sfp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx_valid  (rx.valid),
        .rx_byte   (rx.rx_byte),
        .rx_ready  (rx.ready),
        .buf_count (buf_count),
        .res_valid (res_valid),
        .res       (res)
    );

    sfp_result_buf u_result_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .out_valid (tx.valid),
        .out_ready (tx.ready),
        .out_data  (out_data),
        .count     (buf_count)
    );

    assign tx.kind         = out_data.kind;
    assign tx.frame_id     = out_data.frame_id;
    assign tx.payload_byte = out_data.payload_byte;
    assign tx.byte_index   = out_data.byte_index;
    assign tx.frame_length = out_data.frame_length;
    assign tx.frame_good   = out_data.frame_good;

endmodule

`default_nettype wire

### src/sfp_parser.sv
// Input byte register, configuration registers and the deframing state machine.
// Depends on sfp_pkg; hands one result per byte at most to the result buffer.
`timescale 1ns / 1ps
`default_nettype none

module sfp_parser
    import sfp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CfgIndexW-1:0] cfg_index,
    input  wire logic [CfgDataW-1:0]  cfg_data,
    input  wire logic                 rx_valid,
    input  wire logic [ByteW-1:0]     rx_byte,
    output logic                      rx_ready,
    input  wire logic [BufCntW-1:0]   buf_count,
    output logic                      res_valid,
    output result_t                   res
);

    logic [ByteW-1:0] head_byte_reg;
    logic [ByteW-1:0] max_length_reg;
    logic             stage_valid_reg;
    logic [ByteW-1:0] byte_reg;

    phase_t           phase_reg,   phase_next;
    logic [ByteW-1:0] id_reg,      id_next;
    logic [ByteW-1:0] len_reg,     len_next;
    logic [ByteW-1:0] count_reg,   count_next;
    logic [ByteW-1:0] sum_reg,     sum_next;
    logic [ByteW-1:0] rx_sum_reg,  rx_sum_next;

    logic             rx_accept;
    logic [BufCntW:0] occupancy;

    // Room is reserved for the byte already in the stage, which may still push a result.
    assign occupancy = {1'b0, buf_count} + {{BufCntW{1'b0}}, stage_valid_reg};
    assign rx_ready  = (occupancy < (BufCntW + 1)'(BufDepth));
    assign rx_accept = rx_valid && rx_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_byte_reg  <= HeadByteReset;
            max_length_reg <= MaxLengthReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEAD_BYTE:  head_byte_reg  <= cfg_data[ByteW-1:0];
                CFG_MAX_LENGTH: max_length_reg <= cfg_data[ByteW-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= rx_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_accept)
        begin
            byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEAD;
            id_reg     <= '0;
            len_reg    <= '0;
            count_reg  <= '0;
            sum_reg    <= '0;
            rx_sum_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            id_reg     <= id_next;
            len_reg    <= len_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            rx_sum_reg <= rx_sum_next;
        end
    end

    // Next state of the frame parser.
    always_comb
    begin
        phase_next  = phase_reg;
        id_next     = id_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        rx_sum_next = rx_sum_reg;
        if (stage_valid_reg)
        begin
            case (phase_reg)
                PH_ADDR:
                begin
                    if (byte_reg == head_byte_reg)
                    begin
                        sum_next = byte_reg;
                    end
                    else
                    begin
                        sum_next   = sum_reg + byte_reg;
                        phase_next = PH_ID;
                    end
                end
                PH_ID:
                begin
                    id_next    = byte_reg;
                    sum_next   = sum_reg + byte_reg;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    len_next   = byte_reg;
                    count_next = '0;
                    if (byte_reg > max_length_reg)
                    begin
                        phase_next = PH_HEAD;
                    end
                    else
                    begin
                        sum_next   = sum_reg + byte_reg;
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    // A zero length swallows this byte and moves on to the sum byte.
                    if (count_reg < len_reg)
                    begin
                        sum_next   = sum_reg + byte_reg;
                        count_next = count_reg + 8'd1;
                    end
                    if (count_next >= len_reg)
                    begin
                        phase_next = PH_SUM;
                    end
                end
                PH_SUM:
                begin
                    rx_sum_next = byte_reg;
                    phase_next  = PH_ADD;
                end
                PH_ADD:
                begin
                    phase_next = PH_HEAD;
                end
                default:
                begin
                    phase_next = PH_HEAD;
                    if (byte_reg == head_byte_reg)
                    begin
                        sum_next   = byte_reg;
                        phase_next = PH_ADDR;
                    end
                end
            endcase
        end
    end

    // Result beat for the byte in the stage.
    always_comb
    begin
        res_valid        = 1'b0;
        res.kind         = KIND_PAYLOAD;
        res.frame_id     = id_reg;
        res.payload_byte = '0;
        res.byte_index   = '0;
        res.frame_length = len_reg;
        res.frame_good   = 1'b0;
        case (phase_reg)
            PH_DATA:
            begin
                if (count_reg < len_reg)
                begin
                    res_valid        = stage_valid_reg;
                    res.payload_byte = byte_reg;
                    res.byte_index   = count_reg;
                end
            end
            PH_ADD:
            begin
                res_valid      = stage_valid_reg;
                res.kind       = KIND_END;
                res.frame_good = (rx_sum_reg == sum_reg);
            end
            default: ;
        endcase
    end

    a_index_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == KIND_PAYLOAD) |-> (res.byte_index < res.frame_length))
        else $error("payload beat index beyond the declared length");

    a_end_returns_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && phase_reg == PH_ADD) |=> (phase_reg == PH_HEAD))
        else $error("parser did not return to hunting after the add byte");

    a_data_reached_by_length: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA && !$past(phase_reg == PH_DATA)) |-> $past(phase_reg == PH_LEN))
        else $error("payload phase entered from a phase other than length");

endmodule

`default_nettype wire

### src/sfp_result_buf.sv
// Three-entry result buffer between the parser and the result channel.
// Depends on sfp_pkg for the result type and depth.
`timescale 1ns / 1ps
`default_nettype none

module sfp_result_buf
    import sfp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire result_t            push_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output result_t                 out_data,
    output logic [BufCntW-1:0]      count
);

    result_t              mem [BufDepth];
    logic [BufPtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [BufPtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [BufCntW-1:0]   count_reg,  count_next;
    logic                 pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == BufPtrW'(BufDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == BufPtrW'(BufDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < BufCntW'(BufDepth)))
        else $error("result pushed into a full buffer");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= BufCntW'(BufDepth))
        else $error("result buffer count out of range");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("result buffer count did not follow a push");

endmodule

`default_nettype wire

### tb/serial_frame_parser_sum_check_top_test.sv
// Self-checking testbench for serial_frame_parser_sum_check_top.
// Depends on sfp_pkg, sfp_rx_if, sfp_tx_if and the parser top level; a built-in
// frame predictor checks every payload and end-of-frame beat in order.
`timescale 1ns / 1ps

module serial_frame_parser_sum_check_top_test;
    import sfp_pkg::*;

    localparam int unsigned ClkHalf    = 6;
    localparam int unsigned ResetLen   = 5;
    localparam int unsigned IdleGap    = 8;
    localparam int unsigned LongHold   = 80;
    localparam int unsigned PhaseBytes = 250;
    localparam int unsigned DirCount   = 28;

    localparam logic [CfgIndexW-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CfgIndexW-1:0] CFG_SPARE_HI = 2'd3;

    localparam result_t NoBeat = '0;

    typedef struct packed {
        logic [ByteW-1:0] rx_byte;
        logic             typed;
        result_t          beat;
    } stim_row_t;

    // Directed frames at reset settings: a restart on a repeated head, zero length,
    // an over-long length and a bad sum byte.
    localparam stim_row_t DirRows [DirCount] = '{
        '{8'hFF, 1'b0, NoBeat},
        '{8'hAA, 1'b0, NoBeat},
        '{8'hAA, 1'b0, NoBeat},
        '{8'h01, 1'b0, NoBeat},
        '{8'h07, 1'b0, NoBeat},
        '{8'h02, 1'b0, NoBeat},
        '{8'hFF, 1'b1, '{KIND_PAYLOAD, 8'h07, 8'hFF, 8'h00, 8'h02, 1'b0}},
        '{8'h00, 1'b1, '{KIND_PAYLOAD, 8'h07, 8'h00, 8'h01, 8'h02, 1'b0}},
        '{8'hB3, 1'b0, NoBeat},
        '{8'h55, 1'b1, '{KIND_END, 8'h07, 8'h00, 8'h00, 8'h02, 1'b1}},
        '{8'hAA, 1'b0, NoBeat},
        '{8'h10, 1'b0, NoBeat},
        '{8'h20, 1'b0, NoBeat},
        '{8'h00, 1'b0, NoBeat},
        '{8'h99, 1'b0, NoBeat},
        '{8'hDA, 1'b0, NoBeat},
        '{8'h00, 1'b1, '{KIND_END, 8'h20, 8'h00, 8'h00, 8'h00, 1'b1}},
        '{8'hAA, 1'b0, NoBeat},
        '{8'h00, 1'b0, NoBeat},
        '{8'h33, 1'b0, NoBeat},
        '{8'h65, 1'b0, NoBeat},
        '{8'hAA, 1'b0, NoBeat},
        '{8'h02, 1'b0, NoBeat},
        '{8'h44, 1'b0, NoBeat},
        '{8'h01, 1'b0, NoBeat},
        '{8'h80, 1'b1, '{KIND_PAYLOAD, 8'h44, 8'h80, 8'h00, 8'h01, 1'b0}},
        '{8'h00, 1'b0, NoBeat},
        '{8'hFF, 1'b1, '{KIND_END, 8'h44, 8'h00, 8'h00, 8'h01, 1'b0}}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we;
    logic [CfgIndexW-1:0] cfg_index;
    logic [CfgDataW-1:0]  cfg_data;

    sfp_rx_if rx ();
    sfp_tx_if tx ();

    serial_frame_parser_sum_check_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (rx),
        .tx        (tx)
    );

    // Predictor copy of the parser state and its registers.
    phase_t           parse_ph    = PH_HEAD;
    logic [ByteW-1:0] frame_id_q  = '0;
    logic [ByteW-1:0] length_q    = '0;
    logic [ByteW-1:0] taken_q     = '0;
    logic [ByteW-1:0] sum_q       = '0;
    logic [ByteW-1:0] sum_rx_q    = '0;
    logic [ByteW-1:0] head_cfg    = HeadByteReset;
    logic [ByteW-1:0] max_cfg     = MaxLengthReset;

    result_t     expected_beats [$];
    int unsigned mismatch_count = 0;
    int unsigned frame_bytes    = 0;
    int unsigned gap_pct        = 0;
    int unsigned stall_pct      = 0;
    bit          hold_long      = 1'b0;

    always #(ClkHalf) clk = ~clk;

    // Advances the predicted parser by one byte; returns 1 when a beat is due.
    function automatic bit step_parser(input logic [ByteW-1:0] b, output result_t beat);
        bit due;
        due = 1'b0;
        beat = NoBeat;
        case (parse_ph)
            PH_ADDR:
                if (b == head_cfg)
                    sum_q = b;
                else
                begin
                    sum_q = sum_q + b;
                    parse_ph = PH_ID;
                end
            PH_ID:
            begin
                frame_id_q = b;
                sum_q = sum_q + b;
                parse_ph = PH_LEN;
            end
            PH_LEN:
            begin
                length_q = b;
                taken_q = '0;
                if (b > max_cfg)
                    parse_ph = PH_HEAD;
                else
                begin
                    sum_q = sum_q + b;
                    parse_ph = PH_DATA;
                end
            end
            PH_DATA:
            begin
                // With a zero length this byte is dropped without a beat.
                if (taken_q < length_q)
                begin
                    beat = '{KIND_PAYLOAD, frame_id_q, b, taken_q, length_q, 1'b0};
                    due = 1'b1;
                    sum_q = sum_q + b;
                    taken_q = taken_q + 1'b1;
                end
                if (taken_q >= length_q)
                    parse_ph = PH_SUM;
            end
            PH_SUM:
            begin
                sum_rx_q = b;
                parse_ph = PH_ADD;
            end
            PH_ADD:
            begin
                beat = '{KIND_END, frame_id_q, 8'h00, 8'h00, length_q, sum_rx_q == sum_q};
                due = 1'b1;
                parse_ph = PH_HEAD;
            end
            default:
            begin
                parse_ph = PH_HEAD;
                if (b == head_cfg)
                begin
                    sum_q = b;
                    parse_ph = PH_ADDR;
                end
            end
        endcase
        return due;
    endfunction

    function automatic void check_field(input string name, input logic [ByteW-1:0] want,
                                        input logic [ByteW-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Offers one byte, waits until it is accepted and records what it should produce.
    task automatic send_byte(input logic [ByteW-1:0] b, input logic typed,
                             input result_t typed_beat);
        result_t beat;
        bit      due;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            rx.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx.ready);
        due = step_parser(b, beat);
        if (typed)
            expected_beats.insert(expected_beats.size(), typed_beat);
        else if (due)
            expected_beats.insert(expected_beats.size(), beat);
    endtask

    task automatic wait_idle();
        rx.valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (IdleGap) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_HEAD_BYTE:  head_cfg = val;
            CFG_MAX_LENGTH: max_cfg = val;
            default: ;
        endcase
    endtask

    // Builds one frame with a mostly short length; some carry a bad sum, a repeated
    // head, an over-long length or are cut short.
    task automatic send_frame();
        logic [ByteW-1:0] fb [$];
        logic [ByteW-1:0] flen;
        logic [ByteW-1:0] fsum;
        logic [ByteW-1:0] addr;
        logic [ByteW-1:0] fid;
        logic [ByteW-1:0] pb;
        int unsigned      pick;
        int unsigned      keep;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            flen = 8'($urandom_range(0, (max_cfg < 8) ? max_cfg : 8));
        else if (pick < 88 || max_cfg == 8'hFF)
            flen = 8'($urandom_range(0, max_cfg));
        else
            flen = 8'($urandom_range(max_cfg + 1, 255));
        addr = 8'($urandom);
        if (addr == head_cfg)
            addr = ~addr;
        fid = 8'($urandom);
        fb.insert(fb.size(), head_cfg);
        if ($urandom_range(0, 9) == 0)
            fb.insert(fb.size(), head_cfg);
        fb.insert(fb.size(), addr);
        fb.insert(fb.size(), fid);
        fb.insert(fb.size(), flen);
        fsum = head_cfg + addr + fid + flen;
        if (flen <= max_cfg)
        begin
            if (flen == 0)
                fb.insert(fb.size(), 8'($urandom));
            for (int i = 0; i < flen; i++)
            begin
                pb = 8'($urandom);
                fb.insert(fb.size(), pb);
                fsum = fsum + pb;
            end
            if ($urandom_range(0, 3) == 0)
                fsum = fsum ^ 8'($urandom_range(1, 255));
            fb.insert(fb.size(), fsum);
            fb.insert(fb.size(), 8'($urandom));
        end
        keep = ($urandom_range(0, 99) < 8) ? $urandom_range(1, fb.size() - 1) : fb.size();
        for (int i = 0; i < keep; i++)
        begin
            send_byte(fb[i], 1'b0, NoBeat);
            frame_bytes++;
        end
    endtask

    task automatic run_phase(input logic [ByteW-1:0] head, input logic [ByteW-1:0] maxl,
                             input int unsigned gap, input int unsigned stall,
                             input bit long_hold);
        int unsigned start;
        // Registers change only with the parser hunting and nothing in flight.
        while (parse_ph != PH_HEAD)
            send_byte(~head_cfg, 1'b0, NoBeat);
        wait_idle();
        write_reg(CFG_HEAD_BYTE, head);
        write_reg(CFG_MAX_LENGTH, maxl);
        write_reg(CFG_SPARE_LO, 8'($urandom));
        write_reg(CFG_SPARE_HI, 8'($urandom));
        gap_pct   = gap;
        stall_pct = stall;
        hold_long = long_hold;
        start = frame_bytes;
        while (frame_bytes - start < PhaseBytes)
        begin
            if ($urandom_range(0, 99) < 12)
                send_byte(8'($urandom), 1'b0, NoBeat);
            else
                send_frame();
            if (gap != 0 && $urandom_range(0, 99) < 2)
                wait_idle();
        end
    endtask

    initial
    begin
        rx.valid   <= 1'b0;
        rx.rx_byte <= '0;
        cfg_we     <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        repeat (ResetLen) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct   = 20;
        stall_pct = 20;
        for (int i = 0; i < DirCount; i++)
            send_byte(DirRows[i].rx_byte, DirRows[i].typed, DirRows[i].beat);

        run_phase(8'h00, 8'd0, 0, 30, 1'b0);
        run_phase(8'hFF, 8'd255, 30, 0, 1'b0);
        run_phase(8'h5A, 8'd12, 15, 15, 1'b1);
        run_phase(8'($urandom), 8'($urandom_range(0, 40)), 25, 25, 1'b0);
        run_phase(HeadByteReset, MaxLengthReset, 0, 0, 1'b0);

        wait_idle();
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off that backs up the parser.
    initial
    begin
        tx.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                hold_long = 1'b0;
                tx.ready <= 1'b0;
                repeat (LongHold) @(posedge clk);
                tx.ready <= 1'b1;
            end
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                tx.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                tx.ready <= 1'b1;
            end
            else
                tx.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && tx.valid && tx.ready)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("result beat with no expected beat pending");
                mismatch_count++;
            end
            else
            begin
                want = expected_beats.pop_front();
                check_field("kind", 8'(want.kind), 8'(tx.kind));
                check_field("frame_id", want.frame_id, tx.frame_id);
                check_field("payload_byte", want.payload_byte, tx.payload_byte);
                check_field("byte_index", want.byte_index, tx.byte_index);
                check_field("frame_length", want.frame_length, tx.frame_length);
                check_field("frame_good", 8'(want.frame_good), 8'(tx.frame_good));
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
src/sfp_pkg.sv
src/sfp_rx_if.sv
src/sfp_tx_if.sv
src/sfp_parser.sv
src/sfp_result_buf.sv
src/serial_frame_parser_sum_check_top.sv
tb/serial_frame_parser_sum_check_top_test.sv
